[src/sstk_pkg.sv]
// shared types and codes for the searchable stack
// operation and status codes, controller/datapath command and status structs
package sstk_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FIRST = 2'd2,
    OP_LAST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_OVERFLOW  = 2'd1,
    RES_UNDERFLOW = 2'd2
  } res_e;

  localparam logic [8:0] MATCH_NONE = 9'h1FF;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming item
    logic exec;    // run push, pop or scan setup
    logic scan;    // scan step: issue a read, compare the last one
    logic finish;  // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;  // search on a non-empty stack
    logic scan_end;   // match found or last entry compared
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

[src/sstk_ctrl.sv]
// sequencing controller for the searchable stack
// depends on sstk_pkg for command and status structs
module sstk_ctrl import sstk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/sstk_dp.sv]
// datapath of the searchable stack: entry memory, count, scan pointer, output register
// depends on sstk_pkg for codes and the command and status structs
module sstk_dp import sstk_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] value_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] popped_word_o,
  output logic signed [8:0]  match_index_o,
  output logic [1:0]         status_o,
  output logic [8:0]         occupancy_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rd_data_q;

  op_e           op_q;
  logic [31:0]   key_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] cnt_m1;
  logic          full, empty;

  logic [AW-1:0] ptr_q;
  logic          issued_all_q;
  logic          rd_vld_q;
  logic          rd_last_q;
  logic [AW-1:0] rd_idx_q;
  logic          scan_last;
  logic          hit;

  res_e          res_q;
  logic          pop_ok_q;
  logic [8:0]    match_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;

  logic          out_valid_q;
  logic [31:0]   out_popped_q;
  logic [8:0]    out_match_q;
  logic [1:0]    out_status_q;
  logic [8:0]    out_occ_q;

  assign cnt_m1    = count_q - CW'(1);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign scan_last = (op_q == OP_FIRST) ? (ptr_q == cnt_m1[AW-1:0]) : (ptr_q == '0);
  assign hit       = rd_vld_q && (rd_data_q == key_q);

  assign wr_en   = cmd_i.exec && (op_q == OP_PUSH) && !full;
  assign rd_en   = (cmd_i.exec && (op_q == OP_POP) && !empty) ||
                   (cmd_i.scan && !issued_all_q);
  assign rd_addr = cmd_i.scan ? ptr_q : cnt_m1[AW-1:0];

  assign stat_o.need_scan = ((op_q == OP_FIRST) || (op_q == OP_LAST)) && !empty;
  assign stat_o.scan_end  = rd_vld_q && (hit || rd_last_q);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= key_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // item capture and per-item result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      key_q <= value_i;
    end
    if (cmd_i.exec) begin
      res_q    <= RES_OK;
      pop_ok_q <= 1'b0;
      match_q  <= MATCH_NONE;
      unique case (op_q)
        OP_PUSH: begin
          if (full) begin
            res_q <= RES_OVERFLOW;
          end
        end
        OP_POP: begin
          if (empty) begin
            res_q <= RES_UNDERFLOW;
          end else begin
            pop_ok_q <= 1'b1;
          end
        end
        OP_FIRST: begin
          ptr_q <= '0;
        end
        OP_LAST: begin
          ptr_q <= cnt_m1[AW-1:0];
        end
        default: begin
          ptr_q <= '0;
        end
      endcase
    end
    if (cmd_i.scan) begin
      if (!issued_all_q) begin
        ptr_q <= (op_q == OP_FIRST) ? ptr_q + AW'(1) : ptr_q - AW'(1);
      end
      rd_idx_q  <= ptr_q;
      rd_last_q <= scan_last;
      if (hit) begin
        match_q <= 9'(rd_idx_q);
      end
    end
  end

  // control state: occupancy and scan issue tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      if (cmd_i.exec && (op_q == OP_PUSH) && !full) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.exec && (op_q == OP_POP) && !empty) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.exec) begin
        issued_all_q <= 1'b0;
      end else if (cmd_i.scan && scan_last) begin
        issued_all_q <= 1'b1;
      end
      rd_vld_q <= cmd_i.scan && !issued_all_q;
    end
  end

  // output register, takes a result whenever the previous one has gone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_popped_q <= pop_ok_q ? rd_data_q : '0;
      out_match_q  <= match_q;
      out_status_q <= res_q;
      out_occ_q    <= 9'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_word_o = out_popped_q;
  assign match_index_o = out_match_q;
  assign status_o      = out_status_q;
  assign occupancy_o   = out_occ_q;

endmodule

[src/searchable_stack_unit.sv]
// Fixed-depth stack of DEPTH signed 32-bit words with linear search. Each item is a
// push, a pop, a find-first or a find-last; each yields one result. A push or a pop
// is captured, then executed, then moved into the result register once the output
// register can take it. A search is captured and set up, then scans the entries and
// ends early when an entry matches, then moves its result on the same way. The scan
// reads one entry per cycle from the single read port of the entry memory. A new item
// is accepted once the last one has reached the output register, while its result
// may still wait there. A push when full reports overflow and drops the word; a pop
// when empty reports underflow. Indices count from the bottom of the stack.
// top level: controller sstk_ctrl and datapath sstk_dp, types from sstk_pkg
module searchable_stack_unit import sstk_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] popped_word_o,
  output logic signed [8:0]  match_index_o,
  output logic [1:0]         status_o,
  output logic [8:0]         occupancy_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sstk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sstk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .popped_word_o (popped_word_o),
    .match_index_o (match_index_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

endmodule
